### src/tape_machine_core_unit_macros.svh
// Assertion macros for the tape machine core
`ifndef TAPE_MACHINE_CORE_UNIT_MACROS_SVH
`define TAPE_MACHINE_CORE_UNIT_MACROS_SVH
// implication checked at every clock edge outside reset
`define TMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmc check failed");
// implication checked at the clock edge after the antecedent
`define TMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmc check failed");
`endif

### src/tmc_pkg.sv
// Shared types and constants for the tape machine core
`default_nettype none
package tmc_pkg;
    localparam int ROM_DEPTH  = 4096;
    localparam int PAGE_WORDS = 1024;
    localparam int MAX_PAGES  = 4;
    localparam int WORD_BITS  = 16;
    localparam int MEM_WORDS  = PAGE_WORDS * MAX_PAGES;
    localparam int PA_BITS    = $clog2(ROM_DEPTH);
    localparam int PL_BITS    = PA_BITS + 1;
    localparam int DP_BITS    = $clog2(PAGE_WORDS);
    localparam int PG_BITS    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int MA_BITS    = $clog2(MEM_WORDS);
    localparam int CNT_BITS   = $clog2(MAX_PAGES + 1);

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_STEP   = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FULL    = 2'd1;
    localparam logic [1:0] ERR_BRACKET = 2'd2;

    localparam logic [0:0] REG_STRIP = 1'd0;
    localparam logic [0:0] REG_PAGES = 1'd1;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_JUMP  = 8'h40;
    localparam logic [7:0] CH_COPY  = 8'h5E;
    localparam logic [7:0] CH_PASTE = 8'h2A;
    localparam logic [7:0] CH_ROT   = 8'h7E;
    localparam logic [7:0] CH_NAND  = 8'h26;
    localparam logic [7:0] CH_PAGE  = 8'h23;
    localparam logic [7:0] CH_PNEXT = 8'h7D;
    localparam logic [7:0] CH_PPREV = 8'h7B;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_LOAD_RD, ST_LOAD_WR, ST_EX_RD, ST_EX_JT,
        ST_EX_GO, ST_SKIP_RD, ST_SKIP_CHK, ST_SETTLE, ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;    // write zero at clear address, advance
        logic cap_in;      // capture the request
        logic load_rd;     // read bracket stack top
        logic load_wr;     // commit loaded byte
        logic ex_rd;       // read program byte, cell, target
        logic ex_go;       // execute command
        logic np_adv;      // non-command: pc + 1
        logic skip_rd;     // read program byte at pc
        logic skip_adv;    // pc + 1 during skip
        logic skip_end;    // skip reached the end
        logic finish;      // finish load
        logic status;      // step cannot run: clear running flag
        logic out_load;    // register result
    } tmc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic [1:0] func;
        logic skip;
        logic can_run;     // no error and pc below length
        logic is_cmd;      // byte at pc is a command
        logic pc_at_end;
    } tmc_sts_t;

    function automatic logic is_command(input logic [7:0] c);
        case (c)
            CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OPEN, CH_CLOSE, CH_OUT, CH_IN,
            CH_JUMP, CH_COPY, CH_PASTE, CH_ROT, CH_NAND, CH_PAGE, CH_PNEXT,
            CH_PPREV: is_command = 1'b1;
            default: is_command = 1'b0;
        endcase
    endfunction
endpackage
`default_nettype wire

### src/tmc_ram.sv
// Generic single-port-write, single-read RAM with registered read
`default_nettype none
module tmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/tmc_ctrl.sv
// Controller state machine for the tape machine core
`default_nettype none
module tmc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tmc_pkg::tmc_cmd_t      cmd,
    input  wire tmc_pkg::tmc_sts_t sts
);
    import tmc_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   accept;
    logic   slot_free;

    // output slot frees when empty or taken this cycle
    assign slot_free = !ov_reg || !out_stall;
    assign in_stall  = !(state_reg == ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:     if (accept) state_next = ST_LOAD_RD;
            ST_LOAD_RD:
            begin
                case (sts.func)
                    FUNC_LOAD: state_next = ST_LOAD_WR;
                    FUNC_STEP: state_next = ST_EX_RD;
                    default:   state_next = ST_SETTLE;
                endcase
            end
            ST_LOAD_WR:  state_next = ST_DONE;
            ST_EX_RD:    state_next = sts.can_run ? ST_EX_JT : ST_DONE;
            ST_EX_JT:    state_next = ST_EX_GO;
            ST_EX_GO:    state_next = (sts.is_cmd && sts.skip) ? ST_SKIP_RD : ST_SETTLE;
            ST_SKIP_RD:  state_next = ST_SKIP_CHK;
            ST_SKIP_CHK:
            begin
                if (sts.is_cmd || sts.pc_at_end) state_next = ST_DONE;
                else state_next = ST_SKIP_RD;
            end
            // cell read picks up the new address and written word
            ST_SETTLE:   state_next = ST_DONE;
            ST_DONE:     if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd     = '0;
        ov_next = ov_reg && out_stall;
        case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE:     cmd.cap_in = accept;
            ST_LOAD_RD:
            begin
                cmd.load_rd = 1'b1;
                cmd.finish  = (sts.func == FUNC_FINISH);
            end
            ST_LOAD_WR:  cmd.load_wr = 1'b1;
            ST_EX_RD:
            begin
                cmd.ex_rd  = 1'b1;
                cmd.status = !sts.can_run;
            end
            ST_EX_GO:
            begin
                cmd.ex_go  = sts.is_cmd;
                cmd.np_adv = !sts.is_cmd;
                cmd.skip_rd = 1'b0;
            end
            ST_SKIP_RD:  cmd.skip_rd = 1'b1;
            ST_SKIP_CHK:
            begin
                cmd.skip_adv = !sts.is_cmd && !sts.pc_at_end;
                cmd.skip_end = sts.pc_at_end;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

### src/tmc_dp.sv
// Datapath: program, jump, stack and data memories plus machine registers
`default_nettype none
module tmc_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tmc_pkg::tmc_cmd_t         cmd,
    output tmc_pkg::tmc_sts_t              sts,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [2:0]                cfg_data,
    input  wire logic [1:0]                func,
    input  wire logic [7:0]                program_byte,
    input  wire logic                      skip_noncommands,
    input  wire logic [tmc_pkg::WORD_BITS-1:0] io_read_data,
    output logic                           running,
    output logic [1:0]                     error_code,
    output logic [11:0]                    program_counter,
    output logic [9:0]                     data_pointer,
    output logic [1:0]                     current_page,
    output logic [15:0]                    cell_value,
    output logic [15:0]                    cycle_count,
    output logic                           io_write_valid,
    output logic                           io_read_valid,
    output logic [15:0]                    io_address,
    output logic [15:0]                    io_write_data
);
    import tmc_pkg::*;

    // configuration
    logic                strip_reg;
    logic [2:0]          pcount_reg;
    // request capture
    logic [1:0]          func_reg;
    logic [7:0]          byte_reg;
    logic                skip_reg;
    logic [15:0]         rd_reg;
    // machine state
    logic [PL_BITS-1:0]  sdepth_reg, sdepth_next;
    logic [PL_BITS-1:0]  plen_reg, plen_next;
    logic [1:0]          lerr_reg, lerr_next;
    logic [PL_BITS-1:0]  pc_reg, pc_next;
    logic [DP_BITS-1:0]  dp_reg, dp_next;
    logic [PG_BITS-1:0]  page_reg, page_next;
    logic [15:0]         buf_reg, buf_next;
    logic [15:0]         time_reg, time_next;
    logic                wv_reg, rv_reg;
    logic [15:0]         wd_reg;
    logic                run_reg, run_next;
    logic [MA_BITS:0]    clr_reg;
    logic [7:0]          cmd_byte_reg;

    // memory ports
    logic                pm_we;
    logic [PA_BITS-1:0]  pm_wa, pm_ra;
    logic [7:0]          pm_rd;
    logic                jt_we;
    logic [PA_BITS-1:0]  jt_wa, jt_ra;
    logic [PA_BITS-1:0]  jt_wd, jt_rd;
    logic                bs_we;
    logic [PA_BITS-1:0]  bs_rd;
    logic                dm_we;
    logic [MA_BITS-1:0]  dm_wa, dm_ra, cell_addr;
    logic [15:0]         dm_wd, dm_rd;
    logic                jt2_pend_reg;
    logic [PA_BITS-1:0]  jt2_addr_reg, jt2_data_reg;

    logic [1:0]          eff_err;
    logic [CNT_BITS-1:0] npages;
    logic                byte_ok;
    logic [7:0]          pbyte;

    tmc_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_prog (
        .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(byte_reg),
        .raddr(pm_ra), .rdata(pm_rd));
    tmc_ram #(.WIDTH(PA_BITS), .DEPTH(ROM_DEPTH)) u_jump (
        .clk(clk), .we(jt_we), .waddr(jt_wa), .wdata(jt_wd),
        .raddr(jt_ra), .rdata(jt_rd));
    tmc_ram #(.WIDTH(PA_BITS), .DEPTH(ROM_DEPTH)) u_stack (
        .clk(clk), .we(bs_we), .waddr(sdepth_reg[PA_BITS-1:0]),
        .wdata(plen_reg[PA_BITS-1:0]),
        .raddr(sdepth_reg[PA_BITS-1:0] - 1'b1), .rdata(bs_rd));
    tmc_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_data (
        .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
        .raddr(dm_ra), .rdata(dm_rd));

    // derived values
    always_comb
    begin
        if (lerr_reg != ERR_NONE) eff_err = lerr_reg;
        else if (sdepth_reg != '0) eff_err = ERR_BRACKET;
        else eff_err = ERR_NONE;
        if (pcount_reg == 3'd0) npages = CNT_BITS'(1);
        else if (32'(pcount_reg) > MAX_PAGES) npages = CNT_BITS'(MAX_PAGES);
        else npages = CNT_BITS'(pcount_reg);
        cell_addr = MA_BITS'({page_reg, dp_reg});
        byte_ok   = !strip_reg || is_command(byte_reg);
        pbyte     = (pc_reg < plen_reg) ? pm_rd : 8'd0;
    end

    assign sts.clr_done  = (clr_reg == (MA_BITS+1)'(MEM_WORDS - 1));
    assign sts.func      = func_reg;
    assign sts.skip      = skip_reg;
    assign sts.can_run   = (eff_err == ERR_NONE) && (pc_reg < plen_reg);
    assign sts.is_cmd    = is_command(pbyte);
    assign sts.pc_at_end = (pc_reg >= plen_reg);

    // memory address and write control
    always_comb
    begin
        pm_we = cmd.load_wr && byte_ok && (plen_reg < PL_BITS'(ROM_DEPTH));
        pm_wa = plen_reg[PA_BITS-1:0];
        pm_ra = pc_reg[PA_BITS-1:0];
        bs_we = pm_we && (byte_reg == CH_OPEN) && (sdepth_reg < PL_BITS'(ROM_DEPTH));
        jt_ra = pc_reg[PA_BITS-1:0];
        jt_we = pm_we || jt2_pend_reg;
        if (jt2_pend_reg)
        begin
            jt_wa = jt2_addr_reg;
            jt_wd = jt2_data_reg;
        end
        else
        begin
            jt_wa = plen_reg[PA_BITS-1:0];
            jt_wd = (byte_reg == CH_CLOSE && sdepth_reg != '0) ? bs_rd : '0;
        end
        dm_ra = cell_addr;
        dm_wa = cell_addr;
        dm_we = 1'b0;
        dm_wd = '0;
        if (cmd.clr_step)
        begin
            dm_we = 1'b1;
            dm_wa = clr_reg[MA_BITS-1:0];
        end
        else if (cmd.ex_go)
        begin
            case (cmd_byte_reg)
                CH_INC:   begin dm_we = 1'b1; dm_wd = dm_rd + 16'd1; end
                CH_DEC:   begin dm_we = 1'b1; dm_wd = dm_rd - 16'd1; end
                CH_IN:    begin dm_we = 1'b1; dm_wd = rd_reg; end
                CH_PASTE: begin dm_we = 1'b1; dm_wd = buf_reg; end
                CH_ROT:   begin dm_we = 1'b1; dm_wd = {dm_rd[14:0], dm_rd[15]}; end
                CH_NAND:  begin dm_we = 1'b1; dm_wd = ~(buf_reg & dm_rd); end
                default:  dm_we = 1'b0;
            endcase
        end
    end

    // next machine state
    always_comb
    begin
        sdepth_next = sdepth_reg;
        plen_next   = plen_reg;
        lerr_next   = lerr_reg;
        pc_next     = pc_reg;
        dp_next     = dp_reg;
        page_next   = page_reg;
        buf_next    = buf_reg;
        time_next   = time_reg;
        run_next    = run_reg;
        if (cmd.load_wr && byte_ok)
        begin
            if (plen_reg >= PL_BITS'(ROM_DEPTH))
            begin
                if (lerr_reg == ERR_NONE) lerr_next = ERR_FULL;
            end
            else
            begin
                plen_next = plen_reg + 1'b1;
                if (bs_we) sdepth_next = sdepth_reg + 1'b1;
                else if (byte_reg == CH_CLOSE)
                begin
                    if (sdepth_reg == '0)
                    begin
                        if (lerr_reg == ERR_NONE) lerr_next = ERR_BRACKET;
                    end
                    else sdepth_next = sdepth_reg - 1'b1;
                end
            end
        end
        if (cmd.finish)
        begin
            pc_next = '0; dp_next = '0; page_next = '0; buf_next = '0; time_next = '0;
        end
        if (cmd.np_adv) pc_next = pc_reg + 1'b1;
        if (cmd.ex_go)
        begin
            pc_next   = pc_reg + 1'b1;
            time_next = time_reg + 16'd1;
            case (cmd_byte_reg)
                CH_RIGHT: dp_next = dp_reg + 1'b1;
                CH_LEFT:  dp_next = dp_reg - 1'b1;
                CH_OPEN:  if (dm_rd == 16'd0) pc_next = PL_BITS'(jt_rd) + 1'b1;
                CH_CLOSE: if (dm_rd != 16'd0) pc_next = PL_BITS'(jt_rd);
                CH_JUMP:  dp_next = dm_rd[DP_BITS-1:0];
                CH_COPY:  buf_next = dm_rd;
                CH_PAGE:  if (dm_rd < 16'(npages)) page_next = dm_rd[PG_BITS-1:0];
                CH_PNEXT:
                begin
                    if (32'(page_reg) >= 32'(npages) - 1) page_next = '0;
                    else page_next = page_reg + 1'b1;
                end
                CH_PPREV:
                begin
                    if (page_reg == '0 || 32'(page_reg) > 32'(npages) - 1)
                        page_next = PG_BITS'(npages - 1'b1);
                    else page_next = page_reg - 1'b1;
                end
                default: pc_next = pc_reg + 1'b1;
            endcase
        end
        if (cmd.skip_adv) pc_next = pc_reg + 1'b1;
        // result running flag
        if (cmd.cap_in) run_next = 1'b1;
        if (cmd.status || cmd.skip_end) run_next = 1'b0;
        if (cmd.load_rd && func_reg != FUNC_STEP) run_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg <= 1'b0; pcount_reg <= 3'd1;
            sdepth_reg <= '0; plen_reg <= '0; lerr_reg <= '0;
            pc_reg <= '0; dp_reg <= '0; page_reg <= '0; buf_reg <= '0; time_reg <= '0;
            clr_reg <= '0; jt2_pend_reg <= 1'b0; wv_reg <= 1'b0; rv_reg <= 1'b0;
            run_reg <= 1'b0; func_reg <= FUNC_LOAD;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STRIP: strip_reg  <= cfg_data[0];
                    REG_PAGES: pcount_reg <= cfg_data;
                    default:   strip_reg  <= strip_reg;
                endcase
            end
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            sdepth_reg <= sdepth_next; plen_reg <= plen_next; lerr_reg <= lerr_next;
            pc_reg <= pc_next; dp_reg <= dp_next; page_reg <= page_next;
            buf_reg <= buf_next; time_reg <= time_next; run_reg <= run_next;
            // partner entry of a matched close bracket, written next cycle
            jt2_pend_reg <= pm_we && (byte_reg == CH_CLOSE) && (sdepth_reg != '0);
            if (cmd.cap_in)
            begin
                func_reg <= func;
                wv_reg   <= 1'b0;
                rv_reg   <= 1'b0;
            end
            if (cmd.ex_go)
            begin
                wv_reg <= (cmd_byte_reg == CH_OUT);
                rv_reg <= (cmd_byte_reg == CH_IN);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            byte_reg <= program_byte;
            skip_reg <= skip_noncommands;
            rd_reg   <= io_read_data;
        end
        jt2_addr_reg <= bs_rd;
        jt2_data_reg <= plen_reg[PA_BITS-1:0];
        cmd_byte_reg <= pbyte;
        if (cmd.ex_go) wd_reg <= dm_rd;
        if (cmd.out_load)
        begin
            running         <= run_reg && (func_reg == FUNC_STEP ? 1'b1 :
                               (eff_err == ERR_NONE && pc_reg < plen_reg));
            error_code      <= eff_err;
            program_counter <= (pc_reg > PL_BITS'(4095)) ? 12'hFFF : pc_reg[11:0];
            data_pointer    <= 10'(dp_reg);
            current_page    <= 2'(page_reg);
            cell_value      <= dm_rd;
            cycle_count     <= time_reg;
            io_write_valid  <= wv_reg;
            io_read_valid   <= rv_reg;
            io_address      <= buf_reg;
            io_write_data   <= wv_reg ? wd_reg : 16'd0;
        end
    end
endmodule
`default_nettype wire

### src/tape_machine_core_unit.sv
// Top level of the tape machine core
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | func, program_byte, skip_noncommands, io_read_data
// out     | output    | out_valid/stall  | running ... io_write_data
// cfg     | input     | cfg_we           | cfg_index, cfg_data
// Each request is captured in IDLE and read in LOAD_RD; a load then writes in LOAD_WR,
// finish and unused codes pass SETTLE, and a step runs EX_RD, EX_JT and EX_GO, then SETTLE or,
// when skipping, SKIP_RD and SKIP_CHK per skipped byte, or goes from EX_RD to DONE when
// an error or the program end blocks it. After reset a clearing pass writes all 4096
// data words, one per cycle, while no request is taken. A stalled result holds the request behind it.
`default_nettype none
module tape_machine_core_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  program_byte,
    input  wire logic        skip_noncommands,
    input  wire logic [15:0] io_read_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             running,
    output logic [1:0]       error_code,
    output logic [11:0]      program_counter,
    output logic [9:0]       data_pointer,
    output logic [1:0]       current_page,
    output logic [15:0]      cell_value,
    output logic [15:0]      cycle_count,
    output logic             io_write_valid,
    output logic             io_read_valid,
    output logic [15:0]      io_address,
    output logic [15:0]      io_write_data
);
    import tmc_pkg::*;

    tmc_cmd_t cmd;
    tmc_sts_t sts;

    tmc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

    tmc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .func(func), .program_byte(program_byte),
        .skip_noncommands(skip_noncommands), .io_read_data(io_read_data),
        .running(running), .error_code(error_code),
        .program_counter(program_counter), .data_pointer(data_pointer),
        .current_page(current_page), .cell_value(cell_value),
        .cycle_count(cycle_count), .io_write_valid(io_write_valid),
        .io_read_valid(io_read_valid), .io_address(io_address),
        .io_write_data(io_write_data));
endmodule
`default_nettype wire

### src/tmc_checker.sv
// Port-level checker for the tape machine core, bound to the top level
`default_nettype none
`include "tape_machine_core_unit_macros.svh"
module tmc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        running,
    input wire logic [1:0]  error_code,
    input wire logic        io_write_valid,
    input wire logic        io_read_valid,
    input wire logic [15:0] io_write_data
);
    `TMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `TMC_ASSERT_IMP(a_err_stops, clk, rst_n, out_valid && error_code != 2'd0, !running)
    `TMC_ASSERT_IMP(a_one_io, clk, rst_n, out_valid, !(io_write_valid && io_read_valid))
    `TMC_ASSERT_IMP(a_wdata_zero, clk, rst_n, out_valid && !io_write_valid,
        io_write_data == 16'd0)
    `TMC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind tape_machine_core_unit tmc_checker u_tmc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .running(running),
    .error_code(error_code), .io_write_valid(io_write_valid),
    .io_read_valid(io_read_valid), .io_write_data(io_write_data));
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the tape machine core: load, finish and step requests
`timescale 1ns / 100ps
module testbench;
    import tmc_pkg::*;

    localparam logic [1:0] FUNC_IDLE = 2'd3;   // unused function code
    localparam int CYCLE_LIMIT = 2500000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        run;
        logic [1:0]  err;
        logic [11:0] pc;
        logic [9:0]  dp;
        logic [1:0]  pg;
        logic [15:0] cell_word;
        logic [15:0] cnt;
        logic        wv;
        logic        rv;
        logic [15:0] addr;
        logic [15:0] wd;
    } step_status_t;

    typedef struct {
        logic [1:0]  f;
        logic [7:0]  b;
        logic        s;
        logic [15:0] rd;
        logic        chk;
        logic        x_run;
        logic [1:0]  x_err;
        logic [11:0] x_pc;
    } request_row_t;

    logic clk, rst_n;
    logic cfg_we, cfg_index;
    logic [2:0] cfg_data;
    logic in_valid, in_stall;
    logic [1:0] func;
    logic [7:0] program_byte;
    logic skip_noncommands;
    logic [15:0] io_read_data;
    logic out_valid, out_stall;
    logic running, io_write_valid, io_read_valid;
    logic [1:0] error_code, current_page;
    logic [11:0] program_counter;
    logic [9:0] data_pointer;
    logic [15:0] cell_value, cycle_count, io_address, io_write_data;

    tape_machine_core_unit dut (.*);

    // machine state mirror
    logic [7:0]  prog_mem [ROM_DEPTH];
    logic [11:0] partner [ROM_DEPTH];
    logic [11:0] open_stack [ROM_DEPTH];
    logic [15:0] tape [MEM_WORDS];
    int          depth, plen, pc, dp, pg;
    logic [1:0]  load_err;
    logic [15:0] buf_word, tick;
    logic        strip_cfg;
    logic [2:0]  pages_cfg;

    step_status_t status_q[$];
    request_row_t directed[$];
    int  mismatches, cycles, sent;
    bit  calm, hold_start, hold_taken;
    int  stall_left;

    logic [7:0] plain_ops [14] = '{CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN,
        CH_JUMP, CH_COPY, CH_PASTE, CH_ROT, CH_NAND, CH_PAGE, CH_PNEXT, CH_PPREV};

    function automatic bit is_op(input logic [7:0] c);
        return c inside {CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OPEN, CH_CLOSE, CH_OUT,
            CH_IN, CH_JUMP, CH_COPY, CH_PASTE, CH_ROT, CH_NAND, CH_PAGE, CH_PNEXT,
            CH_PPREV};
    endfunction

    function automatic logic [7:0] byte_at(input int i);
        return (i >= plen) ? 8'h00 : prog_mem[i];
    endfunction

    function automatic int pages_used();
        if (pages_cfg == 0) return 1;
        if (pages_cfg > MAX_PAGES) return MAX_PAGES;
        return pages_cfg;
    endfunction

    function automatic logic [1:0] cur_err();
        if (load_err != ERR_NONE) return load_err;
        if (depth != 0) return ERR_BRACKET;
        return ERR_NONE;
    endfunction

    // one program byte into the store, with bracket matching
    task automatic store_byte(input logic [7:0] b);
        int o;
        if (strip_cfg && !is_op(b))
            return;
        if (plen >= ROM_DEPTH) begin
            if (load_err == ERR_NONE) load_err = ERR_FULL;
            return;
        end
        prog_mem[plen] = b;
        partner[plen] = '0;
        if (b == CH_OPEN) begin
            if (depth < ROM_DEPTH) begin
                open_stack[depth] = plen[11:0];
                depth++;
            end
        end else if (b == CH_CLOSE) begin
            if (depth == 0) begin
                if (load_err == ERR_NONE) load_err = ERR_BRACKET;
            end else begin
                depth--;
                o = open_stack[depth];
                partner[plen] = o[11:0];
                partner[o] = plen[11:0];
            end
        end
        plen++;
    endtask

    // execute the command c at pc
    task automatic run_command(input logic [7:0] c, input logic [15:0] rd,
                               inout step_status_t r);
        int a, n, nxt;
        logic [15:0] v;
        a = pg * PAGE_WORDS + dp;
        v = tape[a];
        n = pages_used();
        nxt = pc + 1;
        case (c)
            CH_RIGHT: dp = (dp + 1 >= PAGE_WORDS) ? 0 : dp + 1;
            CH_LEFT:  dp = (dp == 0) ? PAGE_WORDS - 1 : dp - 1;
            CH_INC:   tape[a] = v + 16'd1;
            CH_DEC:   tape[a] = v - 16'd1;
            CH_OUT:   begin r.wv = 1'b1; r.wd = v; end
            CH_IN:    begin r.rv = 1'b1; tape[a] = rd; end
            CH_OPEN:  if (v == 0) nxt = partner[pc] + 1;
            CH_CLOSE: if (v != 0) nxt = partner[pc];
            CH_JUMP:  dp = v % PAGE_WORDS;
            CH_COPY:  buf_word = v;
            CH_PASTE: tape[a] = buf_word;
            CH_ROT:   tape[a] = {v[14:0], v[15]};
            CH_NAND:  tape[a] = ~(buf_word & v);
            CH_PAGE:  if (v < n) pg = v;
            CH_PNEXT: pg = (pg >= n - 1) ? 0 : pg + 1;
            CH_PPREV: pg = (pg == 0 || pg > n - 1) ? n - 1 : pg - 1;
            default: ;
        endcase
        pc = nxt;
    endtask

    // predicted status for one accepted request
    task automatic apply_request(input logic [1:0] f, input logic [7:0] b, input logic s,
                                 input logic [15:0] rd, output step_status_t r);
        logic [7:0] c;
        bit done;
        r = '0;
        if (f == FUNC_LOAD)
            store_byte(b);
        else if (f == FUNC_FINISH) begin
            pc = 0; dp = 0; pg = 0; buf_word = '0; tick = '0;
        end
        if (f == FUNC_STEP) begin
            r.run = 1'b0;
            if (cur_err() == ERR_NONE && pc < plen) begin
                r.run = 1'b1;
                c = byte_at(pc);
                if (!is_op(c))
                    pc++;
                else begin
                    run_command(c, rd, r);
                    tick++;
                    done = 0;
                    while (s && !done && !is_op(byte_at(pc))) begin
                        if (pc >= plen) begin
                            r.run = 1'b0;
                            done = 1;
                        end else
                            pc++;
                    end
                end
            end
        end else
            r.run = (cur_err() == ERR_NONE && pc < plen);
        r.err  = cur_err();
        r.pc   = (pc > 4095) ? 12'd4095 : pc[11:0];
        r.dp   = dp[9:0];
        r.pg   = pg[1:0];
        r.cell_word = tape[pg * PAGE_WORDS + dp];
        r.cnt  = tick;
        r.addr = buf_word;
    endtask

    // clock, reset, timeout
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            stall_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk) begin
        step_status_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{running, error_code, program_counter, data_pointer, current_page,
                    cell_value, cycle_count, io_write_valid, io_read_valid, io_address,
                    io_write_data};
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0d: expected %p, got %p", cycles, want, got);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request and wait for it to be taken
    task automatic send(input logic [1:0] f, input logic [7:0] b, input logic s,
                        input logic [15:0] rd, input request_row_t row);
        int g;
        step_status_t r;
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        program_byte <= b;
        skip_noncommands <= s;
        io_read_data <= rd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_request(f, b, s, rd, r);
        if (row.chk) begin
            r.run = row.x_run;
            r.err = row.x_err;
            r.pc  = row.x_pc;
        end
        status_q.push_back(r);
        sent++;
    endtask

    task automatic send_plain(input logic [1:0] f, input logic [7:0] b);
        request_row_t none;
        none = '{default: '0};
        send(f, b, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), none);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // both registers, block idle
    task automatic write_regs(input logic strip, input logic [2:0] pages);
        cfg_we <= 1'b1;
        cfg_index <= REG_STRIP;
        cfg_data <= {2'b00, strip};
        @(posedge clk);
        strip_cfg = strip;
        cfg_index <= REG_PAGES;
        cfg_data <= pages;
        @(posedge clk);
        pages_cfg = pages;
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(input logic [1:0] f, input logic [7:0] b, input logic s,
                           input logic [15:0] rd, input logic chk, input logic xr,
                           input logic [1:0] xe, input logic [11:0] xpc);
        directed.push_back('{f, b, s, rd, chk, xr, xe, xpc});
    endtask

    // random balanced program, then a run of steps
    task automatic random_program();
        int n, open, k;
        logic [7:0] b;
        n = $urandom_range(3, 20);
        open = 0;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 12) begin
                b = CH_OPEN;
                open++;
            end else if (k < 24 && open > 0) begin
                b = CH_CLOSE;
                open--;
            end else if (k < 85)
                b = plain_ops[$urandom_range(0, 13)];
            else begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_OPEN || b == CH_CLOSE) b = b ^ 8'h01;
            end
            send_plain(FUNC_LOAD, b);
            // stray step in the middle of a load
            if ($urandom_range(0, 19) == 0) send_plain(FUNC_STEP, 8'h00);
        end
        repeat (open) send_plain(FUNC_LOAD, CH_CLOSE);
        if ($urandom_range(0, 99) < 20) send_plain(FUNC_FINISH, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(5, 60)) send_plain(FUNC_STEP, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [2:0] page_set [6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd3};
        int phase;
        request_row_t row;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        in_valid = 1'b0; func = '0; program_byte = '0;
        skip_noncommands = 1'b0; io_read_data = '0;
        out_stall = 1'b0; stall_left = 0;
        calm = 0; hold_start = 0; hold_taken = 0;
        mismatches = 0; cycles = 0; sent = 0;
        foreach (tape[i]) tape[i] = '0;
        depth = 0; plen = 0; pc = 0; dp = 0; pg = 0;
        load_err = ERR_NONE; buf_word = '0; tick = '0;
        strip_cfg = 1'b0; pages_cfg = 3'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty program, unused code, every command except right and left, byte extremes
        add_row(FUNC_STEP,   8'h00,    1, 16'h0000, 1, 0, ERR_NONE,    0);
        add_row(FUNC_IDLE,   8'hFF,    0, 16'hFFFF, 1, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_INC,   0, 16'h0000, 1, 1, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_OPEN,  0, 16'h0000, 1, 0, ERR_BRACKET, 0);
        add_row(FUNC_STEP,   8'h00,    0, 16'h0000, 1, 0, ERR_BRACKET, 0);
        add_row(FUNC_LOAD,   CH_DEC,   0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_CLOSE, 0, 16'h0000, 1, 1, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_OUT,   0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   8'h00,    0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_IN,    0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_ROT,   0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_COPY,  0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_NAND,  0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_PASTE, 0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_JUMP,  0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_PAGE,  0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_PNEXT, 0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   CH_PPREV, 0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_LOAD,   8'hFF,    0, 16'h0000, 0, 0, ERR_NONE,    0);
        add_row(FUNC_FINISH, 8'h00,    0, 16'h0000, 1, 1, ERR_NONE,    0);
        for (int i = 0; i < 5; i++)
            add_row(FUNC_STEP, 8'h00, i[0], 16'hFFFF, 0, 0, ERR_NONE, 0);

        write_regs(1'b0, 3'd1);
        foreach (directed[i]) begin
            row = directed[i];
            send(row.f, row.b, row.s, row.rd, row);
        end
        drain();
        write_regs(1'b1, 3'd4);

        // random programs across settings
        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 3) hold_start <= 1'b1;
            random_program();
            if ($urandom_range(0, 2) == 0 || phase < 6) begin
                drain();
                write_regs(1'($urandom_range(0, 1)), page_set[phase < 6 ? phase
                                                          : $urandom_range(0, 5)]);
            end
            phase++;
        end

        // fill the program store, then overflow and a stray bracket
        drain();
        calm = 1;
        write_regs(1'b0, 3'd7);
        while (plen < ROM_DEPTH) send_plain(FUNC_LOAD, CH_INC);
        row = '{FUNC_LOAD, 8'h41, 0, 16'h0, 1, 0, ERR_FULL, 0};
        row.x_pc = (pc > 4095) ? 12'd4095 : pc[11:0];
        send(row.f, row.b, row.s, row.rd, row);
        send_plain(FUNC_LOAD, CH_CLOSE);
        send_plain(FUNC_STEP, 8'h00);
        send_plain(FUNC_FINISH, 8'h00);
        send_plain(FUNC_STEP, 8'h00);
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
